// ===== sv/bmh_pkg.sv =====
// Shared types and constants for the binary min-heap core.
// No dependencies; compile first.
package bmh_pkg;

	localparam int CAPACITY = 256;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KID_W    = IDX_W + 2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] min_value;
		logic                     is_empty;
		logic [CNT_W-1:0]         entry_count;
		logic [1:0]               error_code;
	} rsp_t;

endpackage

// ===== sv/bmh_req_if.sv =====
// Request channel: opcode plus value per beat.
// Depends on bmh_pkg.
interface bmh_req_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic signed [bmh_pkg::DATA_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== sv/bmh_rsp_if.sv =====
// Response channel: heap status per beat.
// Depends on bmh_pkg.
interface bmh_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [bmh_pkg::DATA_W-1:0] min_value;
	logic                              is_empty;
	logic [bmh_pkg::CNT_W-1:0]         entry_count;
	logic [1:0]                        error_code;

	modport source (output valid, output min_value, output is_empty, output entry_count,
		output error_code, input ready);
	modport sink   (input valid, input min_value, input is_empty, input entry_count,
		input error_code, output ready);
endinterface

// ===== sv/bmh_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module bmh_ram #(
	parameter int DEPTH  = 256,
	parameter int WIDTH  = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	output logic [WIDTH-1:0]  rdata_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== sv/bmh_ctrl.sv =====
// Heap sequencer: accepts one request, sifts through the RAM, presents a result.
// Depends on bmh_pkg, bmh_req_if; drives the bmh_ram ports.
module bmh_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	bmh_req_if.sink                         req,
	output logic                            ram_we,
	output logic [bmh_pkg::IDX_W-1:0]       ram_waddr,
	output logic [bmh_pkg::DATA_W-1:0]      ram_wdata,
	output logic [bmh_pkg::IDX_W-1:0]       ram_raddr_a,
	input  logic [bmh_pkg::DATA_W-1:0]      ram_rdata_a,
	output logic [bmh_pkg::IDX_W-1:0]       ram_raddr_b,
	input  logic [bmh_pkg::DATA_W-1:0]      ram_rdata_b,
	output logic                            fin_valid,
	output bmh_pkg::rsp_t                   fin_rsp,
	input  logic                            fin_take
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_EX_LAST, ST_DN_RD, ST_DN_CMP, ST_FIN
	} state_t;

	state_t                            state_q, state_d;
	logic [bmh_pkg::CNT_W-1:0]         count_q, count_d;
	logic [bmh_pkg::IDX_W-1:0]         pos_q, pos_d;
	logic signed [bmh_pkg::DATA_W-1:0] cur_q, cur_d;
	logic signed [bmh_pkg::DATA_W-1:0] root_q;
	bmh_pkg::err_t                     err_q, err_d;

	logic                              accept;
	logic [bmh_pkg::IDX_W-1:0]         parent;
	logic [bmh_pkg::KID_W-1:0]         left, right, count_x;
	logic signed [bmh_pkg::DATA_W-1:0] l_val, r_val, c_val;
	logic                              pick_r;
	logic [bmh_pkg::IDX_W-1:0]         c_idx;

	assign accept  = req.valid && req.ready;
	assign parent  = (pos_q - bmh_pkg::IDX_W'(1)) >> 1;
	assign left    = {1'b0, pos_q, 1'b1};
	assign right   = left + bmh_pkg::KID_W'(1);
	assign count_x = bmh_pkg::KID_W'(count_q);
	assign l_val   = $signed(ram_rdata_a);
	assign r_val   = $signed(ram_rdata_b);
	// smaller child, left one on a tie; the right one only when it exists
	assign pick_r  = (right < count_x) && (r_val < l_val);
	assign c_val   = pick_r ? r_val : l_val;
	assign c_idx   = pick_r ? right[bmh_pkg::IDX_W-1:0] : left[bmh_pkg::IDX_W-1:0];

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pos_d       = pos_q;
		cur_d       = cur_q;
		err_d       = err_q;
		req.ready   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = cur_q;
		ram_raddr_a = parent;
		ram_raddr_b = right[bmh_pkg::IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				err_d     = bmh_pkg::ERR_NONE;
				ram_raddr_a = bmh_pkg::IDX_W'(count_q - bmh_pkg::CNT_W'(1));
				if (req.valid) begin
					if (req.opcode == bmh_pkg::OP_INSERT) begin
						if (count_q == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY)) begin
							err_d   = bmh_pkg::ERR_FULL;
							state_d = ST_FIN;
						end else begin
							cur_d   = req.value;
							pos_d   = bmh_pkg::IDX_W'(count_q);
							count_d = count_q + bmh_pkg::CNT_W'(1);
							state_d = ST_UP_RD;
						end
					end else begin
						if (count_q == '0) begin
							err_d   = bmh_pkg::ERR_EMPTY;
							state_d = ST_FIN;
						end else begin
							count_d = count_q - bmh_pkg::CNT_W'(1);
							// last entry read now; nothing to sift when it was the only one
							state_d = (count_q == bmh_pkg::CNT_W'(1)) ? ST_FIN : ST_EX_LAST;
						end
					end
				end
			end
			ST_UP_RD: begin
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				ram_we = 1'b1;
				if (cur_q < l_val) begin
					// move parent down, climb one level
					ram_wdata = ram_rdata_a;
					pos_d     = parent;
					state_d   = ST_UP_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_EX_LAST: begin
				cur_d   = l_val;
				pos_d   = '0;
				state_d = ST_DN_RD;
			end
			ST_DN_RD: begin
				ram_raddr_a = left[bmh_pkg::IDX_W-1:0];
				if (left >= count_x) begin
					ram_we  = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				ram_we = 1'b1;
				if (c_val < cur_q) begin
					// lift the smaller child, descend one level
					ram_wdata = c_val;
					pos_d     = c_idx;
					state_d   = ST_DN_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			err_q   <= bmh_pkg::ERR_NONE;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

	// datapath registers: no reset needed
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		cur_q <= cur_d;
		if (ram_we && ram_waddr == '0) begin
			root_q <= $signed(ram_wdata);
		end
	end

	assign fin_valid             = (state_q == ST_FIN);
	assign fin_rsp.min_value     = (count_q != '0) ? root_q : '0;
	assign fin_rsp.is_empty      = (count_q == '0);
	assign fin_rsp.entry_count   = count_q;
	assign fin_rsp.error_code    = err_q;

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count moved without an accepted request");

	a_root_track: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_waddr == '0) |=> root_q == $signed($past(ram_wdata)))
		else $error("root shadow missed a write to entry zero");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == bmh_pkg::OP_INSERT
			&& count_q == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY))
		|=> (state_q == ST_FIN && err_q == bmh_pkg::ERR_FULL))
		else $error("insert on full heap not flagged");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_FIN) |-> !ram_we)
		else $error("RAM write outside a sift");

endmodule

// ===== sv/binary_min_heap_core.sv =====
// Binary min-heap core: top level with heap RAM, sequencer and result register.
// Depends on bmh_pkg, bmh_req_if, bmh_rsp_if, bmh_ram, bmh_ctrl.
//
// The core keeps up to bmh_pkg::CAPACITY signed 32-bit entries as an array-based
// min-heap in a single RAM (one write port, two registered read ports). Each
// request beat is an insert or an extract-min and yields exactly one response
// beat carrying the root after the operation (zero when empty), an empty flag,
// the entry count and an error code. One request is processed at a time; the
// time taken is set by the sift loop, which spends a read state and a compare
// state on each tree level because the RAM read data is registered. Error
// cases and extracting the last entry go straight from idle to the result
// state, and the sequencer holds its result until the result register is free.
// The response sits in an output register, so the next request is taken while
// the previous response still waits for ready. RAM contents need no clearing
// after reset: only entries below the count are read.
module binary_min_heap_core (
	input  logic       clk,
	input  logic       arst_n,
	bmh_req_if.sink    req,
	bmh_rsp_if.source  rsp
);

	logic                          ram_we;
	logic [bmh_pkg::IDX_W-1:0]     ram_waddr;
	logic [bmh_pkg::DATA_W-1:0]    ram_wdata;
	logic [bmh_pkg::IDX_W-1:0]     ram_raddr_a;
	logic [bmh_pkg::DATA_W-1:0]    ram_rdata_a;
	logic [bmh_pkg::IDX_W-1:0]     ram_raddr_b;
	logic [bmh_pkg::DATA_W-1:0]    ram_rdata_b;

	logic                          fin_valid;
	bmh_pkg::rsp_t                 fin_rsp;
	logic                          fin_take;

	logic                          out_valid_q;
	bmh_pkg::rsp_t                 out_q;

	// heap storage
	bmh_ram #(
		.DEPTH (bmh_pkg::CAPACITY),
		.WIDTH (bmh_pkg::DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

	// sift sequencer
	bmh_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_rdata_a (ram_rdata_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_b (ram_rdata_b),
		.fin_valid   (fin_valid),
		.fin_rsp     (fin_rsp),
		.fin_take    (fin_take)
	);

	// load the result register when it is empty or draining this cycle
	assign fin_take = fin_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload holds while the beat is stalled
	always_ff @(posedge clk) begin
		if (fin_take) begin
			out_q <= fin_rsp;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.min_value   = out_q.min_value;
	assign rsp.is_empty    = out_q.is_empty;
	assign rsp.entry_count = out_q.entry_count;
	assign rsp.error_code  = out_q.error_code;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !fin_take)
		else $error("result register overwritten while stalled");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fin_take |=> out_valid_q)
		else $error("result not presented after load");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid |-> !req.ready)
		else $error("request taken while a result is pending in the sequencer");

endmodule
